@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int ID_W      = 16;
    localparam int PRIO_W    = 4;
    localparam int STATUS_W  = 2;
    localparam int CAP_W     = 5;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [PRIO_W-1:0] PRIO_MIN  = 4'd1;
    localparam logic [PRIO_W-1:0] PRIO_MAX  = 4'd10;
    localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;

    // register index taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic ACT_ADMIT  = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_REMOVED   = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_SHIFT = 3'd1,
        S_PLACE = 3'd2,
        S_READ  = 3'd3,
        S_DONE  = 3'd4
    } t_state;

endpackage

@@ rtl/spq_if.sv @@
// ----------------------------------------------------------------------------
// spq_if
// Valid/ready channels of the sorted priority queue: request and result.
// ----------------------------------------------------------------------------
interface spq_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] item_id;
    logic [3:0]  item_priority;

    modport source (output valid, action, item_id, item_priority, input ready);
    modport sink   (input valid, action, item_id, item_priority, output ready);
endinterface

interface spq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [3:0]  out_priority;

    modport source (output valid, status, out_id, out_priority, input ready);
    modport sink   (input valid, status, out_id, out_priority, output ready);
endinterface

@@ rtl/spq_cfg.sv @@
// ----------------------------------------------------------------------------
// spq_cfg
// APB register block holding the capacity register.
// ----------------------------------------------------------------------------
module spq_cfg
    import spq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [CAP_W-1:0]  o_capacity
);

    logic [CAP_W-1:0] r_capacity;
    logic             reg_hit;

    assign reg_hit = (paddr[APB_AW-1] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata     = reg_hit ? {{(APB_DW-CAP_W){1'b0}}, r_capacity} : '0;
    assign pready     = 1'b1;
    assign o_capacity = r_capacity;

endmodule

@@ rtl/spq_store.sv @@
// ----------------------------------------------------------------------------
// spq_store
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spq_store
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_entry                   i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_entry                   o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: insertion from the rear, removal at the head, result register.
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [CAP_W-1:0]         i_capacity,
    spq_req_if.sink                  i_req,
    spq_rsp_if.source                o_rsp,
    output logic                     o_we,
    output logic [$clog2(DEPTH)-1:0] o_waddr,
    output t_entry                   o_wdata,
    output logic                     o_re,
    output logic [$clog2(DEPTH)-1:0] o_raddr,
    input  t_entry                   i_rdata
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [IW:0]   DEPTH_W = (IW+1)'(DEPTH);
    localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);

    function automatic logic [IW-1:0] slot_at(input logic [IW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, head} + (IW+1)'(off);
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[IW-1:0];
    endfunction

    t_state              r_state, n_state;
    logic [IW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_k, n_k;
    t_entry              r_new, n_new;
    t_status             r_res_status, n_res_status;
    logic [ID_W-1:0]     r_res_id, n_res_id;
    logic [PRIO_W-1:0]   r_res_prio, n_res_prio;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [ID_W-1:0]     r_out_id, n_out_id;
    logic [PRIO_W-1:0]   r_out_prio, n_out_prio;

    logic [EW-1:0]       cap_e;
    logic [EW-1:0]       eff_cap;
    logic                full;
    logic [PRIO_W-1:0]   prio_in;
    t_entry              entry_in;
    logic [CW-1:0]       wr_off;
    logic [CW-1:0]       rd_off;
    logic                load_out;

    // clamp capacity to 1..DEPTH
    always_comb begin
        cap_e = EW'(i_capacity);
        if (cap_e == '0) begin
            eff_cap = EW'(1);
        end else if (cap_e > DEPTH_E) begin
            eff_cap = DEPTH_E;
        end else begin
            eff_cap = cap_e;
        end
    end

    assign full = (EW'(r_count) >= eff_cap);

    // clamp priority to 1..10
    always_comb begin
        if (i_req.item_priority < PRIO_MIN) begin
            prio_in = PRIO_MIN;
        end else if (i_req.item_priority > PRIO_MAX) begin
            prio_in = PRIO_MAX;
        end else begin
            prio_in = i_req.item_priority;
        end
    end

    assign entry_in.prio = prio_in;
    assign entry_in.id   = i_req.item_id;
    assign load_out      = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_k          = r_k;
        n_new        = r_new;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_prio   = r_res_prio;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_prio   = r_out_prio;
        o_we         = 1'b0;
        o_wdata      = r_new;
        o_re         = 1'b0;
        wr_off       = r_k;
        rd_off       = r_k - CW'(2);
        i_req.ready  = 1'b0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // refuse requests while reset is held
                i_req.ready = i_rst_n;
                if (i_req.valid && i_rst_n) begin
                    n_res_id   = '0;
                    n_res_prio = '0;
                    n_state    = S_DONE;
                    if (i_req.action == ACT_ADMIT) begin
                        if (full) begin
                            n_res_status = ST_OVERFLOW;
                        end else if (r_count == '0) begin
                            o_we         = 1'b1;
                            wr_off       = '0;
                            o_wdata      = entry_in;
                            n_count      = r_count + CW'(1);
                            n_res_status = ST_INSERTED;
                        end else begin
                            n_new   = entry_in;
                            o_re    = 1'b1;
                            rd_off  = r_count - CW'(1);
                            n_k     = r_count;
                            n_state = S_SHIFT;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_status = ST_UNDERFLOW;
                        end else begin
                            o_re    = 1'b1;
                            rd_off  = '0;
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_SHIFT: begin
                o_we   = 1'b1;
                wr_off = r_k;
                if (i_rdata.prio > r_new.prio) begin
                    // move the worse entry one place back
                    o_wdata = i_rdata;
                    n_k     = r_k - CW'(1);
                    if (r_k == CW'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        o_re   = 1'b1;
                        rd_off = r_k - CW'(2);
                    end
                end else begin
                    o_wdata      = r_new;
                    n_count      = r_count + CW'(1);
                    n_res_status = ST_INSERTED;
                    n_state      = S_DONE;
                end
            end
            S_PLACE: begin
                o_we         = 1'b1;
                wr_off       = r_k;
                o_wdata      = r_new;
                n_count      = r_count + CW'(1);
                n_res_status = ST_INSERTED;
                n_state      = S_DONE;
            end
            S_READ: begin
                n_res_status = ST_REMOVED;
                n_res_id     = i_rdata.id;
                n_res_prio   = i_rdata.prio;
                n_head       = slot_at(r_head, CW'(1));
                n_count      = r_count - CW'(1);
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_id     = r_res_id;
                    n_out_prio   = r_res_prio;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_waddr = slot_at(r_head, wr_off);
    assign o_raddr = slot_at(r_head, rd_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k          <= n_k;
        r_new        <= n_new;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_prio   <= n_res_prio;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_prio   <= n_out_prio;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.out_id       = r_out_id;
    assign o_rsp.out_priority = r_out_prio;

endmodule

@@ rtl/sorted_priority_queue.sv @@
// Sequence: the result register loads from S_DONE once the previous result has been taken;
//   refusals and an admit into an empty queue go straight to S_DONE, a removal passes
//   through S_READ, and any other admit walks the store from the rear in S_SHIFT (then S_PLACE
//   if the new entry reaches the front). One request at a time: another is taken only in S_IDLE.
// Reset: synchronous, active low; empties the queue, head to slot 0, capacity to 16.
//   The store is not cleared; only slots holding live entries are ever read.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept in priority order in a circular entry store.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    spq_req_if.sink           i_req,
    spq_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int IW = $clog2(DEPTH);

    // capacity as written; clamped to 1..DEPTH inside the sequencer
    logic [CAP_W-1:0] capacity;

    // store ports
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    t_entry        mem_rdata;

    // Register block: a write lands on the access phase; pready stays high.
    spq_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    // Sequencer: take one request at a time, walk the store from the rear on
    // an admit, read the head on a removal, then hand the result to the
    // output register. The output register lets the walk finish while the
    // previous result still waits downstream.
    spq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (capacity),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .o_we       (mem_we),
        .o_waddr    (mem_waddr),
        .o_wdata    (mem_wdata),
        .o_re       (mem_re),
        .o_raddr    (mem_raddr),
        .i_rdata    (mem_rdata)
    );

    // Entry store: identifier and priority side by side in one word.
    spq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

@@ rtl/spq_checker.sv @@
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker
    import spq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [15:0] i_out_id,
    input logic [3:0]  i_out_priority,
    input logic        i_pready
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_out_id) && $stable(i_out_priority))
        else $error("stalled result changed");

    // a removed entry always carries a priority from 1 to 10
    a_removed_prio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_REMOVED) |->
            (i_out_priority >= PRIO_MIN) && (i_out_priority <= PRIO_MAX))
        else $error("removed entry with priority out of range");

    // other results carry zero fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_REMOVED) |->
            (i_out_id == '0) && (i_out_priority == '0))
        else $error("non-removal result with non-zero fields");

    // no result can appear in the cycle right after a request is taken
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared too early");

    a_pready: assert property (@(posedge i_clk) i_pready)
        else $error("pready dropped");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_out_id       (o_rsp.out_id),
    .i_out_priority (o_rsp.out_priority),
    .i_pready       (pready)
);
